@@ rtl/core/pcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_pkg: shared types and constants for the point covariance rotation core
// Request and result structs, CORDIC stage count, angle constants, atan table.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SQRT_ITERS    = 24;

  localparam logic signed [33:0] PI_Q28       = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28  = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28   = 34'sd1686629713;
  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

  typedef struct packed {
    logic               action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_cov_xx;
    logic signed [31:0] in_cov_xy;
    logic signed [31:0] in_cov_xz;
    logic signed [31:0] in_cov_yy;
    logic signed [31:0] in_cov_yz;
    logic signed [31:0] in_cov_zz;
    logic signed [31:0] rotate_angle;
    logic [15:0]        volume_id;
  } pcr_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_cov_xx;
    logic signed [31:0] out_cov_xy;
    logic signed [31:0] out_cov_xz;
    logic signed [31:0] out_cov_yy;
    logic signed [31:0] out_cov_yz;
    logic signed [31:0] out_cov_zz;
    logic [15:0]        out_volume_id;
    logic signed [31:0] angle_used;
  } pcr_out_t;

  typedef struct packed {
    pcr_in_t            req;
    logic signed [31:0] ang;
  } pcr_item_t;

  typedef struct packed {
    pcr_item_t          item;
    logic signed [31:0] cs;
    logic signed [31:0] sn;
  } pcr_rot_t;

  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/point_covariance_rotation_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle while the result is not stalled; the square roots,
// both CORDICs and the multipliers are fully pipelined, one iteration per register stage.
// A stalled result freezes the whole pipeline until it is taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// point_covariance_rotation_core: XY rotation of a point and its covariance
// Angle derivation, sine/cosine, product and rounding stages.
// ----------------------------------------------------------------------------
module point_covariance_rotation_core import pcr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pcr_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pcr_out_t      out_data_o
);

  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v);
    logic signed [65:0] r;
    logic signed [31:0] o;
    r = (v + 66'sd536870912) >>> 30;
    if (r > 66'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (r < -66'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

  logic     en;
  logic     out_valid_q;
  logic     dv_vld, sc_vld;
  pcr_item_t dv_item;
  pcr_rot_t  sc_rot;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  pcr_derive u_derive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .valid_o (dv_vld),
    .item_o  (dv_item)
  );

  pcr_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .item_i  (dv_item),
    .valid_o (sc_vld),
    .rot_o   (sc_rot)
  );

  logic               v1_q, v2_q, v3_q;
  pcr_rot_t           p1_q, p2_q;
  pcr_item_t          p3_q;
  logic signed [63:0] cc_p_q, ss_p_q, sc_p_q;
  logic signed [31:0] cc_q, ss_q, sc_q, ccmss_q;
  logic signed [32:0] dyx_q;
  logic signed [63:0] cc_r, ss_r, sc_r;

  assign cc_r = (cc_p_q + 64'sd536870912) >>> 30;
  assign ss_r = (ss_p_q + 64'sd536870912) >>> 30;
  assign sc_r = (sc_p_q + 64'sd536870912) >>> 30;

  logic signed [63:0] m_xc_q, m_ys_q, m_yc_q, m_xs_q;
  logic signed [63:0] m_xxcc_q, m_xysc_q, m_yyss_q, m_xyd_q;
  logic signed [64:0] m_dsc_q;
  logic signed [63:0] m_xzc_q, m_yzs_q, m_yzc_q, m_xzs_q, m_xxss_q, m_yycc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= sc_vld;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= sc_rot;
      cc_p_q <= 64'(sc_rot.cs) * 64'(sc_rot.cs);
      ss_p_q <= 64'(sc_rot.sn) * 64'(sc_rot.sn);
      sc_p_q <= 64'(sc_rot.sn) * 64'(sc_rot.cs);

      p2_q    <= p1_q;
      cc_q    <= cc_r[31:0];
      ss_q    <= ss_r[31:0];
      sc_q    <= sc_r[31:0];
      ccmss_q <= cc_r[31:0] - ss_r[31:0];
      dyx_q   <= 33'(p1_q.item.req.in_cov_yy) - 33'(p1_q.item.req.in_cov_xx);

      p3_q     <= p2_q.item;
      m_xc_q   <= 64'(p2_q.cs) * 64'(p2_q.item.req.in_x);
      m_ys_q   <= 64'(p2_q.sn) * 64'(p2_q.item.req.in_y);
      m_yc_q   <= 64'(p2_q.cs) * 64'(p2_q.item.req.in_y);
      m_xs_q   <= 64'(p2_q.sn) * 64'(p2_q.item.req.in_x);
      m_xxcc_q <= 64'(p2_q.item.req.in_cov_xx) * 64'(cc_q);
      m_xysc_q <= 64'(p2_q.item.req.in_cov_xy) * 64'(sc_q);
      m_yyss_q <= 64'(p2_q.item.req.in_cov_yy) * 64'(ss_q);
      m_xyd_q  <= 64'(p2_q.item.req.in_cov_xy) * 64'(ccmss_q);
      m_dsc_q  <= 65'(dyx_q) * 65'(sc_q);
      m_xzc_q  <= 64'(p2_q.item.req.in_cov_xz) * 64'(p2_q.cs);
      m_yzs_q  <= 64'(p2_q.item.req.in_cov_yz) * 64'(p2_q.sn);
      m_yzc_q  <= 64'(p2_q.item.req.in_cov_yz) * 64'(p2_q.cs);
      m_xzs_q  <= 64'(p2_q.item.req.in_cov_xz) * 64'(p2_q.sn);
      m_xxss_q <= 64'(p2_q.item.req.in_cov_xx) * 64'(ss_q);
      m_yycc_q <= 64'(p2_q.item.req.in_cov_yy) * 64'(cc_q);
    end
  end

  pcr_out_t out_d, out_q;

  always_comb begin
    out_d.out_x         = rnd_sat(66'(m_xc_q) + 66'(m_ys_q));
    out_d.out_y         = rnd_sat(66'(m_yc_q) - 66'(m_xs_q));
    out_d.out_z         = p3_q.req.in_z;
    out_d.out_cov_xx    = rnd_sat(66'(m_xxcc_q) + (66'(m_xysc_q) <<< 1) + 66'(m_yyss_q));
    out_d.out_cov_xy    = rnd_sat(66'(m_xyd_q) + 66'(m_dsc_q));
    out_d.out_cov_xz    = rnd_sat(66'(m_xzc_q) + 66'(m_yzs_q));
    out_d.out_cov_yy    = rnd_sat(66'(m_xxss_q) - (66'(m_xysc_q) <<< 1) + 66'(m_yycc_q));
    out_d.out_cov_yz    = rnd_sat(66'(m_yzc_q) - 66'(m_xzs_q));
    out_d.out_cov_zz    = p3_q.req.in_cov_zz;
    out_d.out_volume_id = p3_q.req.volume_id;
    out_d.angle_used    = p3_q.ang;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_given_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !p3_q.req.action) |-> (p3_q.ang == p3_q.req.rotate_angle))
    else $error("given angle not carried through");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_vld |-> (sc_rot.cs <= 32'sd1073741824 && sc_rot.cs >= -32'sd1073741824 &&
                sc_rot.sn <= 32'sd1073741824 && sc_rot.sn >= -32'sd1073741824))
    else $error("sine or cosine outside unit range");

  a_hold_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule
`default_nettype wire

@@ rtl/core/pcr_derive.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_derive: detector-plane angle pipeline
// Two bit-serial square roots, a vectoring CORDIC and the quadrant fix,
// one iteration per register stage; selects the angle for each request.
// ----------------------------------------------------------------------------
module pcr_derive import pcr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire pcr_in_t   req_i,
  output logic           valid_o,
  output pcr_item_t      item_o
);

  logic [47:0] sqa_v_q [SQRT_ITERS+1];
  logic [47:0] sqa_r_q [SQRT_ITERS+1];
  logic [47:0] sqb_v_q [SQRT_ITERS+1];
  logic [47:0] sqb_r_q [SQRT_ITERS+1];
  logic        sq_vld_q [SQRT_ITERS+1];
  pcr_in_t     sq_req_q [SQRT_ITERS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqa_v_q[0]  <= req_i.in_cov_xx[31] ? 48'd0 : {1'b0, req_i.in_cov_xx[30:0], 16'd0};
      sqb_v_q[0]  <= req_i.in_cov_yy[31] ? 48'd0 : {1'b0, req_i.in_cov_yy[30:0], 16'd0};
      sqa_r_q[0]  <= 48'd0;
      sqb_r_q[0]  <= 48'd0;
      sq_req_q[0] <= req_i;
    end
  end

  for (genvar k = 0; k < SQRT_ITERS; k++) begin : g_sqrt
    localparam logic [47:0] SqBit = 48'd1 << (46 - 2 * k);
    logic [47:0] ta, tb;
    assign ta = sqa_r_q[k] + SqBit;
    assign tb = sqb_r_q[k] + SqBit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sqa_v_q[k] >= ta) begin
          sqa_v_q[k+1] <= sqa_v_q[k] - ta;
          sqa_r_q[k+1] <= (sqa_r_q[k] >> 1) + SqBit;
        end else begin
          sqa_v_q[k+1] <= sqa_v_q[k];
          sqa_r_q[k+1] <= sqa_r_q[k] >> 1;
        end
        if (sqb_v_q[k] >= tb) begin
          sqb_v_q[k+1] <= sqb_v_q[k] - tb;
          sqb_r_q[k+1] <= (sqb_r_q[k] >> 1) + SqBit;
        end else begin
          sqb_v_q[k+1] <= sqb_v_q[k];
          sqb_r_q[k+1] <= sqb_r_q[k] >> 1;
        end
        sq_req_q[k+1] <= sq_req_q[k];
      end
    end
  end

  logic [23:0] sa, sb;
  assign sa = sqa_r_q[SQRT_ITERS][23:0];
  assign sb = sqb_r_q[SQRT_ITERS][23:0];

  logic signed [43:0] at_x_q [CORDIC_N+1];
  logic signed [43:0] at_y_q [CORDIC_N+1];
  logic signed [33:0] at_z_q [CORDIC_N+1];
  logic               at_zero_q [CORDIC_N+1];
  logic               at_vld_q [CORDIC_N+1];
  pcr_in_t            at_req_q [CORDIC_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      at_vld_q[0] <= sq_vld_q[SQRT_ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      at_x_q[0]    <= $signed({4'd0, sb, 16'd0});
      at_y_q[0]    <= $signed({4'd0, sa, 16'd0});
      at_z_q[0]    <= 34'sd0;
      at_zero_q[0] <= (sa == 24'd0) && (sb == 24'd0);
      at_req_q[0]  <= sq_req_q[SQRT_ITERS];
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_atan
    localparam logic signed [33:0] Step = $signed({2'b00, atan_q30(i)});
    logic signed [43:0] dx, dy;
    assign dx = at_y_q[i] >>> i;
    assign dy = at_x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        at_vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        at_vld_q[i+1] <= at_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!at_y_q[i][43]) begin
          at_x_q[i+1] <= at_x_q[i] + dx;
          at_y_q[i+1] <= at_y_q[i] - dy;
          at_z_q[i+1] <= at_z_q[i] + Step;
        end else begin
          at_x_q[i+1] <= at_x_q[i] - dx;
          at_y_q[i+1] <= at_y_q[i] + dy;
          at_z_q[i+1] <= at_z_q[i] - Step;
        end
        at_zero_q[i+1] <= at_zero_q[i];
        at_req_q[i+1]  <= at_req_q[i];
      end
    end
  end

  pcr_in_t            fx_req;
  logic signed [33:0] phi, phi_d;
  logic signed [32:0] x33, y33, dyx, sxy;
  logic signed [31:0] ang_d;

  always_comb begin
    fx_req = at_req_q[CORDIC_N];
    phi    = at_zero_q[CORDIC_N] ? 34'sd0 : (at_z_q[CORDIC_N] >>> 2);
    x33    = 33'(fx_req.in_x);
    y33    = 33'(fx_req.in_y);
    dyx    = y33 - x33;
    sxy    = x33 + y33;
    phi_d  = phi;
    if (fx_req.in_cov_xy > 32'sd0) begin
      phi_d = PI_Q28 - phi;
      if (dyx < 33'sd0) begin
        phi_d = phi_d + PI_Q28;
      end
    end else if (sxy < 33'sd0) begin
      phi_d = phi + PI_Q28;
    end
    ang_d = fx_req.action ? phi_d[31:0] : fx_req.rotate_angle;
  end

  logic      out_vld_q;
  pcr_item_t out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= at_vld_q[CORDIC_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_item_q.req <= fx_req;
      out_item_q.ang <= ang_d;
    end
  end

  assign valid_o = out_vld_q;
  assign item_o  = out_item_q;

endmodule
`default_nettype wire

@@ rtl/core/pcr_sincos.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcr_sincos: sine and cosine pipeline
// Range reduction, rotation CORDIC one stage per register, clamp and sign fix.
// ----------------------------------------------------------------------------
module pcr_sincos import pcr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire pcr_item_t  item_i,
  output logic            valid_o,
  output pcr_rot_t        rot_o
);

  logic signed [33:0] a0, a1, a2;
  logic               flip_d;

  always_comb begin
    a0 = 34'(item_i.ang);
    if (a0 > PI_Q28) begin
      a1 = a0 - TWO_PI_Q28;
    end else if (a0 < -PI_Q28) begin
      a1 = a0 + TWO_PI_Q28;
    end else begin
      a1 = a0;
    end
    flip_d = 1'b0;
    a2     = a1;
    if (a1 > HALF_PI_Q28) begin
      a2     = a1 - PI_Q28;
      flip_d = 1'b1;
    end else if (a1 < -HALF_PI_Q28) begin
      a2     = a1 + PI_Q28;
      flip_d = 1'b1;
    end
  end

  logic signed [33:0] cx_q [CORDIC_N+1];
  logic signed [33:0] cy_q [CORDIC_N+1];
  logic signed [33:0] cz_q [CORDIC_N+1];
  logic               flip_q [CORDIC_N+1];
  logic               vld_q [CORDIC_N+1];
  pcr_item_t          item_q [CORDIC_N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]   <= INV_GAIN_Q30;
      cy_q[0]   <= 34'sd0;
      cz_q[0]   <= a2 <<< 2;
      flip_q[0] <= flip_d;
      item_q[0] <= item_i;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    localparam logic signed [33:0] Step = $signed({2'b00, atan_q30(i)});
    logic signed [33:0] dx, dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cz_q[i][33]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - Step;
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + Step;
        end
        flip_q[i+1] <= flip_q[i];
        item_q[i+1] <= item_q[i];
      end
    end
  end

  logic signed [33:0] xc, yc, xf, yf;

  always_comb begin
    xc = cx_q[CORDIC_N];
    yc = cy_q[CORDIC_N];
    if (xc > ONE_Q30) begin
      xc = ONE_Q30;
    end else if (xc < -ONE_Q30) begin
      xc = -ONE_Q30;
    end
    if (yc > ONE_Q30) begin
      yc = ONE_Q30;
    end else if (yc < -ONE_Q30) begin
      yc = -ONE_Q30;
    end
    xf = flip_q[CORDIC_N] ? -xc : xc;
    yf = flip_q[CORDIC_N] ? -yc : yc;
  end

  logic     out_vld_q;
  pcr_rot_t out_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[CORDIC_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_rot_q.item <= item_q[CORDIC_N];
      out_rot_q.cs   <= xf[31:0];
      out_rot_q.sn   <= yf[31:0];
    end
  end

  assign valid_o = out_vld_q;
  assign rot_o   = out_rot_q;

endmodule
`default_nettype wire
